FILE: hdl/assert_macros.svh
// Assertion macros shared by the timer queue RTL.
// Each macro clocks on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/stq_pkg.sv
// Shared types and constants for the sorted timer expiry queue.
// Used by stq_cell and sorted_timer_expiry_queue; depends on nothing.
`default_nettype none

package stq_pkg;

	localparam int TimeW = 64;
	localparam int HandleW = 8;
	localparam int DelayW = 32;
	// most expiries reported by one tick
	localparam int MaxResults = 16;

	// request kinds
	localparam logic ReqTick = 1'b0;
	localparam logic ReqAdd  = 1'b1;

	// result event codes
	localparam logic [1:0] EvAddOk   = 2'd0;
	localparam logic [1:0] EvAddFull = 2'd1;
	localparam logic [1:0] EvExpired = 2'd2;
	localparam logic [1:0] EvNone    = 2'd3;

	typedef struct packed {
		logic               valid;
		logic [TimeW-1:0]   deadline;
		logic [HandleW-1:0] handle;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic pop;
	} cell_ctrl_t;

	localparam entry_t EntryEmpty = '{valid: 1'b0, deadline: '0, handle: '0};

endpackage

`default_nettype wire

FILE: hdl/stq_cell.sv
// One slot of the sorted timer chain: holds a deadline and handle.
// Depends on stq_pkg; neighbors are wired by sorted_timer_expiry_queue.
`default_nettype none

module stq_cell
	import stq_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cell_ctrl_t         ctrl,
	input  wire logic [TimeW-1:0]   ins_due,
	input  wire logic [HandleW-1:0] ins_handle,
	input  wire entry_t             prev_ent,
	input  wire logic               prev_earlier,
	input  wire entry_t             next_ent,
	output entry_t                  ent,
	output logic                    earlier
);

	logic               valid_q;
	logic [TimeW-1:0]   deadline_q;
	logic [HandleW-1:0] handle_q;
	entry_t             d;

	assign ent = '{valid: valid_q, deadline: deadline_q, handle: handle_q};
	// new timer goes after every entry strictly earlier than it
	assign earlier = valid_q && (deadline_q < ins_due);

	always_comb begin
		d = ent;
		if (ctrl.pop) begin
			d = next_ent;
		end else if (ctrl.insert && !earlier) begin
			if (prev_earlier) begin
				d = '{valid: 1'b1, deadline: ins_due, handle: ins_handle};
			end else begin
				d = prev_ent;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		deadline_q <= d.deadline;
		handle_q <= d.handle;
	end

endmodule

`default_nettype wire

FILE: hdl/sorted_timer_expiry_queue.sv
// Sorted timer expiry queue: 64-bit tick counter plus a chain of sorted timer cells.
// Depends on stq_pkg, stq_cell and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready): req_type 1 adds timer_handle with a
//   deadline of now + delay_ticks; req_type 0 advances time by one tick.
//   Output channel (out_valid/out_ready): event_code 0 add accepted, 1 add
//   rejected (queue full), 2 timer expired (expired_handle set), 3 tick with
//   nothing due. last_of_run marks the final item caused by one input.
//   Timing: one input item is handled at a time. An add result is registered
//   from ST_ADD once the output register is free, then the block returns to
//   ST_IDLE to take the next item; a tick gives its first result from ST_TICK
//   and then one expiry per cycle while the output is not stalled, up to 16
//   per tick, because the head cell is popped and the chain shifts left behind
//   it. Inserts shift the chain right with one compare per cell.
//   in_ready is high only while no item is being processed.
//   Stall: a held result stays in the output register and the chain waits.
//   Reset: time and all cell valid bits clear at once; no clearing pass.
`default_nettype none

module sorted_timer_expiry_queue
	import stq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               req_type,
	input  wire logic [HandleW-1:0] timer_handle,
	input  wire logic [DelayW-1:0]  delay_ticks,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              event_code,
	output logic [HandleW-1:0]      expired_handle,
	output logic                    last_of_run
);

	localparam int NW = $clog2(MaxResults);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD,
		ST_TICK
	} state_t;

	state_t             state_q;
	logic [TimeW-1:0]   time_q;
	logic [TimeW-1:0]   due_q;
	logic [HandleW-1:0] hnd_q;
	logic [NW-1:0]      cnt_q;
	logic               out_valid_q;
	logic [1:0]         code_q;
	logic [HandleW-1:0] ohnd_q;
	logic               last_q;

	entry_t     ent [QUEUE_DEPTH];
	logic       bef [QUEUE_DEPTH];
	cell_ctrl_t ctrl;
	logic       out_free;
	logic       out_load;
	logic       full;
	logic       head_due;
	logic       next_due;
	logic       cnt_last;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign event_code = code_q;
	assign expired_handle = ohnd_q;
	assign last_of_run = last_q;

	assign out_free = !out_valid_q || out_ready;
	// a busy state always loads a result once the output register is free
	assign out_load = ((state_q == ST_ADD) || (state_q == ST_TICK)) && out_free;
	assign full = ent[QUEUE_DEPTH-1].valid;
	assign head_due = ent[0].valid && (ent[0].deadline <= time_q);
	assign next_due = ent[1].valid && (ent[1].deadline <= time_q);
	assign cnt_last = (cnt_q == NW'(MaxResults - 1));

	always_comb begin
		ctrl.insert = (state_q == ST_ADD) && out_free && !full;
		ctrl.pop = (state_q == ST_TICK) && out_free && head_due;
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   prev_b;

		if (i == 0) begin : g_head
			assign prev_e = EntryEmpty;
			assign prev_b = 1'b1;
		end else begin : g_body
			assign prev_e = ent[i-1];
			assign prev_b = bef[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign next_e = EntryEmpty;
		end else begin : g_mid
			assign next_e = ent[i+1];
		end

		stq_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.ins_due      (due_q),
			.ins_handle   (hnd_q),
			.prev_ent     (prev_e),
			.prev_earlier (prev_b),
			.next_ent     (next_e),
			.ent          (ent[i]),
			.earlier      (bef[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			time_q <= '0;
			due_q <= '0;
			hnd_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			code_q <= EvAddOk;
			ohnd_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q <= '0;
						if (req_type == ReqTick) begin
							time_q <= time_q + TimeW'(1);
							state_q <= ST_TICK;
						end else begin
							due_q <= time_q + {{(TimeW-DelayW){1'b0}}, delay_ticks};
							hnd_q <= timer_handle;
							state_q <= ST_ADD;
						end
					end
				end
				ST_ADD: begin
					if (out_free) begin
						code_q <= full ? EvAddFull : EvAddOk;
						ohnd_q <= '0;
						last_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_TICK: begin
					if (out_free) begin
						if (head_due) begin
							// pop head; stop when nothing else is due or the run is full
							code_q <= EvExpired;
							ohnd_q <= ent[0].handle;
							last_q <= !next_due || cnt_last;
							cnt_q <= cnt_q + NW'(1);
							if (!next_due || cnt_last) begin
								state_q <= ST_IDLE;
							end
						end else begin
							code_q <= EvNone;
							ohnd_q <= '0;
							last_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`include "assert_macros.svh"

	`ASSERT_IMPLIES(a_sorted_head, ent[0].valid && ent[1].valid,
		ent[0].deadline <= ent[1].deadline, "head entries out of deadline order")
	`ASSERT_IMPLIES(a_valid_prefix, ent[QUEUE_DEPTH-1].valid, ent[0].valid,
		"valid entries not packed at head")
	`ASSERT_NEXT(a_tick_time, in_valid && in_ready && req_type == ReqTick,
		time_q == $past(time_q) + TimeW'(1), "tick did not advance time by one")
	`ASSERT_IMPLIES(a_busy_no_ready, state_q != ST_IDLE, !in_ready, "input accepted while busy")

endmodule

`default_nettype wire

FILE: dv/stq_expiry_checker.sv
// Checker for the sorted timer expiry queue: tracks armed timers and tick count,
// predicts every result item and compares it as it leaves the block.
// Depends on stq_pkg for field widths, codes and the per-tick expiry limit.
`timescale 1ns / 100ps
`default_nettype none

module stq_expiry_checker
	import stq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic               req_type,
	input  wire logic [HandleW-1:0] timer_handle,
	input  wire logic [DelayW-1:0]  delay_ticks,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic [1:0]         event_code,
	input  wire logic [HandleW-1:0] expired_handle,
	input  wire logic               last_of_run,
	output int                      fail_count,
	output int                      reports_left
);

	typedef struct {
		logic [TimeW-1:0]   deadline;
		logic [HandleW-1:0] handle;
	} timer_t;

	typedef struct {
		logic [1:0]         code;
		logic [HandleW-1:0] handle;
		logic               last;
	} report_t;

	timer_t           armed_timers[$];
	report_t          pending_reports[$];
	logic [TimeW-1:0] tick_count;
	int               errs;

	function automatic report_t report_of(input logic [1:0] code,
			input logic [HandleW-1:0] handle, input logic last);
		report_t r;
		r.code = code;
		r.handle = handle;
		r.last = last;
		return r;
	endfunction

	// Arm a timer or advance time by one tick, queueing the reports it causes.
	task automatic file_request(input logic kind, input logic [HandleW-1:0] handle,
			input logic [DelayW-1:0] delay);
		logic [TimeW-1:0] due;
		timer_t           t;
		int               pos;
		int               fired;
		if (kind == ReqAdd) begin
			if (armed_timers.size() >= QUEUE_DEPTH) begin
				pending_reports.push_back(report_of(EvAddFull, '0, 1'b1));
			end else begin
				due = tick_count + TimeW'(delay);
				pos = 0;
				// new timer goes ahead of older ones with the same deadline
				while (pos < armed_timers.size() && armed_timers[pos].deadline < due)
					pos++;
				t.deadline = due;
				t.handle = handle;
				armed_timers.insert(pos, t);
				pending_reports.push_back(report_of(EvAddOk, '0, 1'b1));
			end
		end else begin
			tick_count = tick_count + TimeW'(1);
			fired = 0;
			while (fired < MaxResults && armed_timers.size() > 0 &&
					armed_timers[0].deadline <= tick_count) begin
				pending_reports.push_back(report_of(EvExpired, armed_timers[0].handle, 1'b0));
				void'(armed_timers.pop_front());
				fired++;
			end
			if (fired == 0)
				pending_reports.push_back(report_of(EvNone, '0, 1'b1));
			else
				pending_reports[pending_reports.size()-1].last = 1'b1;
		end
	endtask

	always @(posedge clk) begin : watch
		report_t want;
		if (!arst_n) begin
			armed_timers.delete();
			pending_reports.delete();
			tick_count = '0;
			errs = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_reports.size() == 0) begin
					$error("unexpected item: event_code %0d expired_handle %0d last_of_run %0b",
						event_code, expired_handle, last_of_run);
					errs++;
				end else begin
					want = pending_reports.pop_front();
					if (event_code !== want.code) begin
						$error("event_code: expected %0d, got %0d", want.code, event_code);
						errs++;
					end
					if (expired_handle !== want.handle) begin
						$error("expired_handle: expected %0d, got %0d",
							want.handle, expired_handle);
						errs++;
					end
					if (last_of_run !== want.last) begin
						$error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
						errs++;
					end
				end
			end
			if (in_valid && in_ready)
				file_request(req_type, timer_handle, delay_ticks);
		end
		fail_count <= errs;
		reports_left <= pending_reports.size();
	end

endmodule

`default_nettype wire

FILE: dv/tb_sorted_timer_expiry_queue.sv
// Testbench top for sorted_timer_expiry_queue: clock, reset, stimulus and verdict.
// Depends on stq_pkg, the block itself and stq_expiry_checker, which predicts and compares.
`timescale 1ns / 100ps
`default_nettype none

module tb_sorted_timer_expiry_queue;
	import stq_pkg::*;

	localparam int QueueDepth = 16;
	localparam int CycleLimit = 200000;
	localparam int RandomItems = 480;
	localparam int DrainCycles = 20;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               req_type;
	logic [HandleW-1:0] timer_handle;
	logic [DelayW-1:0]  delay_ticks;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         event_code;
	logic [HandleW-1:0] expired_handle;
	logic               last_of_run;
	int                 fail_count;
	int                 reports_left;
	int                 cycle_count;
	int                 send_idle_pct;
	int                 recv_stall_pct;
	int                 wide_delays;

	sorted_timer_expiry_queue #(.QUEUE_DEPTH(QueueDepth)) uut (.*);

	stq_expiry_checker #(.QUEUE_DEPTH(QueueDepth)) checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_sorted_timer_expiry_queue NOT OK");
		$finish;
	end

	// Call at a falling edge; returns at the falling edge after the item is taken.
	task automatic offer_request(input logic kind, input logic [HandleW-1:0] handle,
			input logic [DelayW-1:0] delay);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		timer_handle <= handle;
		delay_ticks <= delay;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int               add_pct;
		int               roll;
		logic [DelayW-1:0] delay;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = ReqTick;
		timer_handle = '0;
		delay_ticks = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		wide_delays = 0;
		add_pct = 50;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// tick on an empty queue
		offer_request(ReqTick, 8'h00, '0);
		// park one timer far beyond the run
		offer_request(ReqAdd, 8'hFF, '1);
		// fill up with repeating deadlines
		for (int k = 0; k < 15; k++)
			offer_request(ReqAdd, HandleW'(k), DelayW'((k % 3) + 1));
		// queue full: reject
		offer_request(ReqAdd, 8'hAA, '0);
		repeat (3) offer_request(ReqTick, 8'h55, 32'hAAAA5555);
		// zero delay expires on the next tick
		offer_request(ReqAdd, 8'h00, '0);
		offer_request(ReqTick, 8'h00, '0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 58;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 58;
				end
				default: begin
					send_idle_pct = 7;
					recv_stall_pct = 7;
				end
			endcase
			for (int i = 0; i < RandomItems / 4; i++) begin
				// vary the add/tick mix so the queue both drains and fills
				if (i % 20 == 0)
					add_pct = 30 + 20 * $urandom_range(2);
				roll = $urandom_range(99);
				if (roll < 80)
					delay = $urandom_range(8);
				else if (roll < 99 || wide_delays >= 3)
					delay = $urandom_range(40);
				else begin
					// wide delays never come due, so keep them few
					delay = $urandom;
					wide_delays++;
				end
				if ($urandom_range(99) < add_pct)
					offer_request(ReqAdd, HandleW'($urandom_range(255)), delay);
				else
					offer_request(ReqTick, HandleW'($urandom_range(255)), DelayW'($urandom));
			end
		end
		in_valid <= 1'b0;

		while (reports_left != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0)
			$display("tb_sorted_timer_expiry_queue OK");
		else
			$display("tb_sorted_timer_expiry_queue NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+hdl
hdl/stq_pkg.sv
hdl/stq_cell.sv
hdl/sorted_timer_expiry_queue.sv
dv/stq_expiry_checker.sv
dv/tb_sorted_timer_expiry_queue.sv
